/* src/cbm_pkg.sv */
// Shared types, codes and helpers for the console bus mapper.
`timescale 1ns / 1ps

package cbm_pkg;

    typedef enum logic [1:0] {
        OP_MEM_READ   = 2'd0,
        OP_MEM_WRITE  = 2'd1,
        OP_PORT_READ  = 2'd2,
        OP_PORT_WRITE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_LOCAL   = 3'd1,
        TGT_BOOTROM = 3'd2,
        TGT_RAM     = 3'd3,
        TGT_CART    = 3'd4,
        TGT_VIDEO   = 3'd5,
        TGT_TONE    = 3'd6,
        TGT_SOUND   = 3'd7
    } target_t;

    typedef enum logic [2:0] {
        SER_NONE      = 3'd0,
        SER_CLK_LOW   = 3'd1,
        SER_CLK_HIGH  = 3'd2,
        SER_DATA_LOW  = 3'd3,
        SER_DATA_HIGH = 3'd4
    } serial_t;

    typedef enum logic [1:0] {
        CART_FLAT   = 2'd0,
        CART_MEGA   = 2'd1,
        CART_EEPROM = 2'd2,
        CART_RSVD   = 2'd3
    } cart_mode_t;

    // Configuration register indexes
    localparam logic CFG_CART_MODE = 1'b0;
    localparam logic CFG_LAST_BANK = 1'b1;

    // Device register codes
    localparam logic [1:0] DEV_NONE      = 2'd0;
    localparam logic [1:0] DEV_SND_LATCH = 2'd0;
    localparam logic [1:0] DEV_SND_WRITE = 2'd1;
    localparam logic [1:0] DEV_SND_READ  = 2'd2;

    // Port numbers and groups (port[7:5])
    localparam logic [7:0] PORT_SND_LATCH = 8'h50;
    localparam logic [7:0] PORT_SND_WRITE = 8'h51;
    localparam logic [7:0] PORT_SND_READ  = 8'h52;
    localparam logic [7:0] PORT_EXP_RAM   = 8'h53;
    localparam logic [2:0] GRP_SOUND      = 3'b010;
    localparam logic [2:0] GRP_BOOT       = 3'b011;
    localparam logic [2:0] GRP_KEYPAD_SEL = 3'b100;
    localparam logic [2:0] GRP_VIDEO      = 3'b101;
    localparam logic [2:0] GRP_JOY_SEL    = 3'b110;
    localparam logic [2:0] GRP_CTRL       = 3'b111;

    // Memory map
    localparam logic [15:0] ADDR_BOOT_END  = 16'h1fff;
    localparam logic [15:0] ADDR_EXP_LO    = 16'h2000;
    localparam logic [15:0] ADDR_EXP_END   = 16'h5fff;
    localparam logic [15:0] ADDR_RAM_LO    = 16'h6000;
    localparam logic [15:0] ADDR_RAM_END   = 16'h7fff;
    localparam logic [15:0] ADDR_SDA_READ  = 16'hff80;
    localparam logic [15:0] ADDR_BANK_1    = 16'hff90;
    localparam logic [15:0] ADDR_BANK_2    = 16'hffa0;
    localparam logic [15:0] ADDR_BANK_3    = 16'hffb0;
    localparam logic [15:0] ADDR_SCL_LOW   = 16'hffc0;
    localparam logic [15:0] ADDR_SCL_HIGH  = 16'hffd0;
    localparam logic [15:0] ADDR_SDA_LOW   = 16'hffe0;
    localparam logic [15:0] ADDR_SDA_HIGH  = 16'hfff0;
    localparam logic [15:0] ADDR_MEGA_LO   = 16'hffc0;
    localparam logic [19:0] RAM_MIRROR_BASE = 20'h06000;

    localparam logic [7:0] OPEN_BUS = 8'hff;
    localparam logic [6:0] JOY_MASK = 7'h7f;

    // Keypad column code cleared by each key, keys 0..11
    localparam logic [3:0] KEY_CODE [12] = '{
        4'h0a, 4'h0d, 4'h07, 4'h0c, 4'h02, 4'h03,
        4'h0e, 4'h05, 4'h01, 4'h0b, 4'h06, 4'h09
    };

    typedef struct packed {
        op_t         operation;
        logic [15:0] address;
        logic [7:0]  write_value;
        logic        sda_level;
        logic [7:0]  joystick_one;
        logic [7:0]  joystick_two;
        logic [15:0] keypad_one;
        logic [15:0] keypad_two;
    } req_t;

    typedef struct packed {
        target_t     target;
        logic [19:0] offset;
        logic [1:0]  device_register;
        logic        write_enable;
        logic [7:0]  local_data;
        serial_t     serial_action;
    } rsp_t;

    // Active-low keypad to controller byte: bit 6 second button, bits 5:4 set
    function automatic logic [7:0] keypad_byte(input logic [15:0] keys);
        logic [3:0] code;
        code = 4'hf;
        for (int i = 0; i < 12; i++) begin
            if (!keys[i]) begin
                code = code & KEY_CODE[i];
            end
        end
        return {1'b0, keys[14], 2'b11, code};
    endfunction

endpackage

/* src/console_bus_mapper.sv */
// Top level of the console bus mapper: address decode, bank switching and port control.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_t: one CPU bus access
// rsp       out        rsp_valid / rsp_ready  rsp_t: target, offset and local data
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data: mode registers
//
// Each access is captured in the request register and then decoded into the
// response register; one access per cycle is sustained while the response side
// does not stall, limited only by the single decode stage.
// Reset clears both valid flags, the mode bits (boot ROM on) and the upper bank.
// A stalled response holds the decode stage; the request side keeps taking a
// transfer whenever the request register empties in the same cycle.
module console_bus_mapper
    import cbm_pkg::*;
#(
    parameter int CART_BANKS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,

    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data
);

    localparam int LAST_MAX = CART_BANKS - 1;

    // Pipeline registers
    logic       req_valid_reg;
    req_t       req_reg;
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;

    // Configuration and mapper state
    cart_mode_t cart_mode_reg;
    logic [5:0] last_bank_reg;
    logic       boot_rom_on_reg;
    logic       boot_rom_on_next;
    logic       expansion_ram_on_reg;
    logic       expansion_ram_on_next;
    logic       joystick_mode_reg;
    logic       joystick_mode_next;
    logic [5:0] upper_bank_reg;
    logic [5:0] upper_bank_next;

    logic       advance;
    logic [5:0] last_bank_eff;
    logic       eep;
    logic       mega;
    logic       banked;
    logic [5:0] bank_sel;
    logic [7:0] port;
    logic [15:0] addr;

    // Move the decoded access forward whenever the response slot is free
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Saturate the last bank to what the cartridge store can hold
    assign last_bank_eff = (int'(last_bank_reg) > LAST_MAX) ? 6'(LAST_MAX) : last_bank_reg;

    assign eep    = (cart_mode_reg == CART_EEPROM);
    assign mega   = (cart_mode_reg == CART_MEGA);
    assign banked = eep || mega;
    assign addr   = req_reg.address;
    assign port   = req_reg.address[7:0];

    always_comb
    begin
        rsp_next                 = '0;
        rsp_next.target          = TGT_NONE;
        rsp_next.device_register = DEV_NONE;
        rsp_next.local_data      = OPEN_BUS;
        rsp_next.serial_action   = SER_NONE;
        boot_rom_on_next         = boot_rom_on_reg;
        expansion_ram_on_next    = expansion_ram_on_reg;
        joystick_mode_next       = joystick_mode_reg;
        upper_bank_next          = upper_bank_reg;
        bank_sel                 = upper_bank_reg;

        case (req_reg.operation)
            OP_MEM_READ, OP_MEM_WRITE:
            begin
                if (addr <= ADDR_BOOT_END) begin
                    if (boot_rom_on_reg) begin
                        if (req_reg.operation == OP_MEM_READ) begin
                            rsp_next.target = TGT_BOOTROM;
                            rsp_next.offset = 20'(addr);
                        end
                    end else begin
                        rsp_next.target       = TGT_RAM;
                        rsp_next.offset       = 20'(addr);
                        rsp_next.write_enable = (req_reg.operation == OP_MEM_WRITE);
                    end
                end else if (addr inside {[ADDR_EXP_LO:ADDR_EXP_END]}) begin
                    if (expansion_ram_on_reg) begin
                        rsp_next.target       = TGT_RAM;
                        rsp_next.offset       = 20'(addr);
                        rsp_next.write_enable = (req_reg.operation == OP_MEM_WRITE);
                    end
                end else if (addr inside {[ADDR_RAM_LO:ADDR_RAM_END]}) begin
                    // Without expansion RAM the 1 KiB RAM mirrors across this window
                    rsp_next.target       = TGT_RAM;
                    rsp_next.write_enable = (req_reg.operation == OP_MEM_WRITE);
                    rsp_next.offset       = expansion_ram_on_reg ? 20'(addr)
                                          : (RAM_MIRROR_BASE | 20'(addr[9:0]));
                end else if (req_reg.operation == OP_MEM_WRITE) begin
                    // Cartridge is never written; EEPROM boards decode control strobes
                    if (eep) begin
                        if (addr == ADDR_BANK_1 || addr == ADDR_BANK_2
                            || addr == ADDR_BANK_3) begin
                            upper_bank_next = {4'b0, addr[5:4]} & last_bank_eff;
                        end else if (addr == ADDR_SCL_LOW) begin
                            rsp_next.serial_action = SER_CLK_LOW;
                        end else if (addr == ADDR_SCL_HIGH) begin
                            rsp_next.serial_action = SER_CLK_HIGH;
                        end else if (addr == ADDR_SDA_LOW) begin
                            rsp_next.serial_action = SER_DATA_LOW;
                        end else if (addr == ADDR_SDA_HIGH) begin
                            rsp_next.serial_action = SER_DATA_HIGH;
                        end
                    end
                end else if (eep && addr == ADDR_SDA_READ) begin
                    rsp_next.target     = TGT_LOCAL;
                    rsp_next.local_data = {7'b0, req_reg.sda_level};
                end else begin
                    // Mega boards switch the upper bank on a read of the top 64 bytes
                    if (mega && addr >= ADDR_MEGA_LO) begin
                        bank_sel        = last_bank_eff - (~addr[5:0] & last_bank_eff);
                        upper_bank_next = bank_sel;
                    end
                    rsp_next.target = TGT_CART;
                    if (!banked) begin
                        rsp_next.offset = 20'(addr[14:0]);
                    end else if (addr[15:14] == 2'b11) begin
                        rsp_next.offset = {bank_sel, addr[13:0]};
                    end else begin
                        rsp_next.offset = {(eep ? 6'b0 : last_bank_eff), addr[13:0]};
                    end
                end
            end

            OP_PORT_READ:
            begin
                case (port[7:5])
                    GRP_SOUND:
                    begin
                        if (port == PORT_SND_READ) begin
                            rsp_next.target          = TGT_SOUND;
                            rsp_next.device_register = DEV_SND_READ;
                        end
                    end
                    GRP_VIDEO:
                    begin
                        rsp_next.target          = TGT_VIDEO;
                        rsp_next.device_register = {1'b0, port[0]};
                    end
                    GRP_CTRL:
                    begin
                        rsp_next.target = TGT_LOCAL;
                        if (joystick_mode_reg) begin
                            rsp_next.local_data = {1'b0, (port[1] ? req_reg.joystick_two[6:0]
                                                          : req_reg.joystick_one[6:0]) & JOY_MASK};
                        end else begin
                            rsp_next.local_data = keypad_byte(port[1] ? req_reg.keypad_two
                                                              : req_reg.keypad_one);
                        end
                    end
                    default:
                    begin
                        rsp_next.target = TGT_NONE;
                    end
                endcase
            end

            OP_PORT_WRITE:
            begin
                case (port[7:5])
                    GRP_SOUND:
                    begin
                        if (port == PORT_SND_LATCH) begin
                            rsp_next.target          = TGT_SOUND;
                            rsp_next.device_register = DEV_SND_LATCH;
                            rsp_next.write_enable    = 1'b1;
                        end else if (port == PORT_SND_WRITE) begin
                            rsp_next.target          = TGT_SOUND;
                            rsp_next.device_register = DEV_SND_WRITE;
                            rsp_next.write_enable    = 1'b1;
                        end else if (port == PORT_EXP_RAM) begin
                            expansion_ram_on_next = req_reg.write_value[0];
                        end
                    end
                    GRP_BOOT:
                    begin
                        boot_rom_on_next = req_reg.write_value[1];
                    end
                    GRP_KEYPAD_SEL, GRP_JOY_SEL:
                    begin
                        joystick_mode_next = port[6];
                    end
                    GRP_VIDEO:
                    begin
                        rsp_next.target          = TGT_VIDEO;
                        rsp_next.device_register = {1'b0, port[0]};
                        rsp_next.write_enable    = 1'b1;
                    end
                    GRP_CTRL:
                    begin
                        rsp_next.target       = TGT_TONE;
                        rsp_next.write_enable = 1'b1;
                    end
                    default:
                    begin
                        rsp_next.target = TGT_NONE;
                    end
                endcase
            end

            default:
            begin
                rsp_next.target = TGT_NONE;
            end
        endcase
    end

    // Control state: valid flags, modes, bank and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg        <= 1'b0;
            rsp_valid_reg        <= 1'b0;
            boot_rom_on_reg      <= 1'b1;
            expansion_ram_on_reg <= 1'b0;
            joystick_mode_reg    <= 1'b0;
            upper_bank_reg       <= '0;
            cart_mode_reg        <= CART_FLAT;
            last_bank_reg        <= '0;
        end else begin
            if (req_ready) begin
                req_valid_reg <= req_valid;
            end
            if (advance) begin
                rsp_valid_reg        <= 1'b1;
                boot_rom_on_reg      <= boot_rom_on_next;
                expansion_ram_on_reg <= expansion_ram_on_next;
                joystick_mode_reg    <= joystick_mode_next;
                upper_bank_reg       <= upper_bank_next;
            end else if (rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_CART_MODE: cart_mode_reg <= cart_mode_t'(cfg_data[1:0]);
                    CFG_LAST_BANK: last_bank_reg <= cfg_data;
                    default:       last_bank_reg <= last_bank_reg;
                endcase
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready) begin
            req_reg <= req;
        end
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

/* tb/sv/cbm_tb_pkg.sv */
// Scoreboard for the console bus mapper bench: access decode prediction and response checks.
`timescale 1ns / 1ps
package cbm_tb_pkg;
    import cbm_pkg::*;

    class bus_map_scoreboard;
        int         num_banks;
        cart_mode_t mode;
        logic [5:0] bank_mask;
        logic       boot_on;
        logic       exp_ram_on;
        logic       joy_mode;
        logic [5:0] hi_bank;
        rsp_t       expected_rsp [$];
        int         mismatches;

        function new(int banks);
            num_banks  = banks;
            mode       = CART_FLAT;
            bank_mask  = '0;
            boot_on    = 1'b1;
            exp_ram_on = 1'b0;
            joy_mode   = 1'b0;
            hi_bank    = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [5:0] data);
            if (idx == CFG_CART_MODE)
                mode = cart_mode_t'(data[1:0]);
            else
                bank_mask = data;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // Append one predicted response behind the ones already outstanding
        function void queue_response(rsp_t r);
            expected_rsp.insert(expected_rsp.size(), r);
        endfunction

        // Decode one accepted access, update the mode and bank state, queue the response.
        function void note_access(req_t acc);
            localparam logic [47:0] KEY_COLS = 48'h96b15e32c7da;
            rsp_t        r;
            logic [5:0]  lb;
            logic [7:0]  port;
            logic [15:0] keys;
            logic [3:0]  col;
            logic        wr;
            r.target          = TGT_NONE;
            r.offset          = '0;
            r.device_register = DEV_NONE;
            r.write_enable    = 1'b0;
            r.local_data      = OPEN_BUS;
            r.serial_action   = SER_NONE;
            lb = (int'(bank_mask) > num_banks - 1) ? 6'(num_banks - 1) : bank_mask;
            port = acc.address[7:0];
            if (acc.operation == OP_MEM_READ || acc.operation == OP_MEM_WRITE) begin
                wr = (acc.operation == OP_MEM_WRITE);
                if (acc.address <= ADDR_BOOT_END) begin
                    if (boot_on) begin
                        if (!wr)
                        begin
                            r.target = TGT_BOOTROM;
                            r.offset = {4'h0, acc.address};
                        end
                    end
                    else
                    begin
                        r.target       = TGT_RAM;
                        r.offset       = {4'h0, acc.address};
                        r.write_enable = wr;
                    end
                end
                else if (acc.address <= ADDR_EXP_END)
                begin
                    if (exp_ram_on)
                    begin
                        r.target       = TGT_RAM;
                        r.offset       = {4'h0, acc.address};
                        r.write_enable = wr;
                    end
                end
                else if (acc.address <= ADDR_RAM_END)
                begin
                    r.target       = TGT_RAM;
                    r.write_enable = wr;
                    r.offset       = exp_ram_on ? {4'h0, acc.address}
                                                : RAM_MIRROR_BASE + {10'h0, acc.address[9:0]};
                end
                else if (wr)
                begin
                    if (mode == CART_EEPROM)
                    begin
                        case (acc.address)
                            ADDR_BANK_1, ADDR_BANK_2, ADDR_BANK_3:
                                hi_bank = {4'h0, acc.address[5:4]} & lb;
                            ADDR_SCL_LOW:  r.serial_action = SER_CLK_LOW;
                            ADDR_SCL_HIGH: r.serial_action = SER_CLK_HIGH;
                            ADDR_SDA_LOW:  r.serial_action = SER_DATA_LOW;
                            ADDR_SDA_HIGH: r.serial_action = SER_DATA_HIGH;
                            default: ;
                        endcase
                    end
                end
                else if (mode == CART_EEPROM && acc.address == ADDR_SDA_READ)
                begin
                    r.target     = TGT_LOCAL;
                    r.local_data = {7'h0, acc.sda_level};
                end
                else
                begin
                    if (mode == CART_MEGA && acc.address >= ADDR_MEGA_LO)
                        hi_bank = lb - (~acc.address[5:0] & lb);
                    r.target = TGT_CART;
                    if (mode != CART_MEGA && mode != CART_EEPROM)
                        r.offset = {5'h0, acc.address[14:0]};
                    else if (acc.address[15:14] == 2'b11)
                        r.offset = {hi_bank, acc.address[13:0]};
                    else
                        r.offset = {(mode == CART_EEPROM) ? 6'h0 : lb, acc.address[13:0]};
                end
            end
            else if (acc.operation == OP_PORT_READ)
            begin
                case (port[7:5])
                    GRP_SOUND:
                        if (port == PORT_SND_READ)
                        begin
                            r.target          = TGT_SOUND;
                            r.device_register = DEV_SND_READ;
                        end
                    GRP_VIDEO:
                    begin
                        r.target          = TGT_VIDEO;
                        r.device_register = {1'b0, port[0]};
                    end
                    GRP_CTRL:
                    begin
                        r.target = TGT_LOCAL;
                        if (joy_mode)
                            r.local_data = {1'b0, port[1] ? acc.joystick_two[6:0]
                                                          : acc.joystick_one[6:0]};
                        else
                        begin
                            keys = port[1] ? acc.keypad_two : acc.keypad_one;
                            col  = 4'hf;
                            for (int i = 0; i < 12; i++)
                                if (!keys[i])
                                    col = col & KEY_COLS[i*4 +: 4];
                            r.local_data = {1'b0, keys[14], 2'b11, col};
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (port[7:5])
                    GRP_SOUND:
                        if (port == PORT_SND_LATCH)
                        begin
                            r.target          = TGT_SOUND;
                            r.device_register = DEV_SND_LATCH;
                            r.write_enable    = 1'b1;
                        end
                        else if (port == PORT_SND_WRITE)
                        begin
                            r.target          = TGT_SOUND;
                            r.device_register = DEV_SND_WRITE;
                            r.write_enable    = 1'b1;
                        end
                        else if (port == PORT_EXP_RAM)
                            exp_ram_on = acc.write_value[0];
                    GRP_BOOT:
                        boot_on = acc.write_value[1];
                    GRP_KEYPAD_SEL, GRP_JOY_SEL:
                        joy_mode = port[6];
                    GRP_VIDEO:
                    begin
                        r.target          = TGT_VIDEO;
                        r.device_register = {1'b0, port[0]};
                        r.write_enable    = 1'b1;
                    end
                    GRP_CTRL:
                    begin
                        r.target       = TGT_TONE;
                        r.write_enable = 1'b1;
                    end
                    default: ;
                endcase
            end
            queue_response(r);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with nothing outstanding: tgt=%0d off=%05h",
                             $time, got.target, got.offset);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.target !== want.target || got.offset !== want.offset
                || got.device_register !== want.device_register
                || got.write_enable !== want.write_enable
                || got.local_data !== want.local_data
                || got.serial_action !== want.serial_action)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp tgt=%0d off=%05h reg=%0d we=%0b data=%02h ser=%0d",
                             $time, want.target, want.offset, want.device_register,
                             want.write_enable, want.local_data, want.serial_action,
                             " | got tgt=%0d off=%05h reg=%0d we=%0b data=%02h ser=%0d",
                             got.target, got.offset, got.device_register,
                             got.write_enable, got.local_data, got.serial_action);
            end
        endfunction
    endclass

endpackage

/* tb/sv/console_bus_mapper_tb.sv */
// Self-checking bench for the console bus mapper: directed and random bus accesses.
`timescale 1ns / 1ps
module console_bus_mapper_tb;
    import cbm_pkg::*;
    import cbm_tb_pkg::*;

    localparam int CART_BANKS       = 64;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int NUM_PHASES       = 8;
    localparam int DRAIN_CYCLES     = 8;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [5:0] cfg_data  = '0;

    // Percent of cycles in which the sender idles and the receiver stalls
    int idle_pct  = 14;
    int stall_pct = 14;
    int cycles    = 0;

    bus_map_scoreboard sb;

    // Mode and last bank per random phase; a negative bank means pick one at random
    cart_mode_t phase_mode [NUM_PHASES] = '{CART_MEGA, CART_EEPROM, CART_RSVD, CART_MEGA,
                                            CART_EEPROM, CART_MEGA, CART_EEPROM, CART_FLAT};
    int         phase_bank [NUM_PHASES] = '{63, 63, 5, 0, 1, -1, -1, -1};

    // Ports that decode to something, plus a few that decode to nothing
    logic [7:0] port_pick [16] = '{PORT_SND_LATCH, PORT_SND_WRITE, PORT_SND_READ,
                                   PORT_EXP_RAM, 8'h60, 8'h7f, 8'h80, 8'hc0,
                                   8'ha0, 8'ha1, 8'he0, 8'he2, 8'hff, 8'hfd,
                                   8'h00, 8'h54};

    console_bus_mapper #(.CART_BANKS(CART_BANKS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the response side at random; stall_pct of zero gives a clean stretch
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch all three channels at the edge: every transfer feeds the scoreboard
    // in the order the block sees it, so predicted state tracks the block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (req_valid && req_ready)
                sb.note_access(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("console_bus_mapper_tb: FAIL");
            $finish;
        end
    end

    // Build one access with random controller inputs; keypads often have one key down
    function automatic req_t make_access(op_t op, logic [15:0] addr, logic [7:0] value);
        req_t a;
        a.operation    = op;
        a.address      = addr;
        a.write_value  = value;
        a.sda_level    = 1'($urandom);
        a.joystick_one = 8'($urandom);
        a.joystick_two = 8'($urandom);
        a.keypad_one   = 16'($urandom);
        a.keypad_two   = 16'($urandom);
        if ($urandom_range(1))
            a.keypad_one = a.keypad_one | (16'h0fff & ~(16'h1 << $urandom_range(11)));
        if ($urandom_range(1))
            a.keypad_two = a.keypad_two | (16'h0fff & ~(16'h1 << $urandom_range(11)));
        return a;
    endfunction

    // Random access: mostly port accesses and the cartridge top page where the bank
    // switch, serial lines and data read live, then the upper window that reads the bank.
    function automatic req_t random_access();
        req_t a;
        int   pick;
        pick = $urandom_range(99);
        a = make_access(op_t'($urandom_range(1) ? OP_MEM_WRITE : OP_MEM_READ),
                        16'($urandom), 8'($urandom));
        if (pick < 30)
            a.address = {12'hff8 + 12'($urandom_range(7)),
                         ($urandom_range(3) == 0) ? 4'($urandom) : 4'h0};
        else if (pick < 42)
            a.address = {2'b11, 14'($urandom)};
        else if (pick < 48)
            a.address = {1'b1, 15'($urandom)};
        else if (pick < 60)
            a.address = 16'($urandom);
        else
        begin
            a.operation = op_t'($urandom_range(1) ? OP_PORT_WRITE : OP_PORT_READ);
            if ($urandom_range(4) != 0)
                a.address[7:0] = port_pick[4'($urandom_range(15))];
        end
        return a;
    endfunction

    // Drive one request and hold it until the transfer; idle first at random.
    task automatic send_access(input req_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Drop the request and wait until every expected response has come back
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One register write; valid drops in its own cycle before any further write
    task automatic program_register(input logic idx, input logic [5:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        req_t       item;
        logic [5:0] bank;
        sb = new(CART_BANKS);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sweep in flat mode from reset: boot ROM, then RAM once it drops,
        // open bus and mirrored RAM, expansion RAM, cartridge ends, every port group.
        send_access(make_access(OP_MEM_READ,   16'h0000, 8'h00));
        send_access(make_access(OP_MEM_WRITE,  16'h1fff, 8'hff));
        send_access(make_access(OP_PORT_WRITE, 16'h0060, 8'h00));
        send_access(make_access(OP_MEM_WRITE,  16'h0000, 8'h5a));
        send_access(make_access(OP_MEM_READ,   16'h2000, 8'h00));
        send_access(make_access(OP_MEM_READ,   16'h7fff, 8'h00));
        send_access(make_access(OP_PORT_WRITE, 16'hff53, 8'h01));
        send_access(make_access(OP_MEM_WRITE,  16'h5fff, 8'ha5));
        send_access(make_access(OP_MEM_READ,   16'h6000, 8'h00));
        send_access(make_access(OP_MEM_READ,   16'h8000, 8'h00));
        send_access(make_access(OP_MEM_READ,   16'hffff, 8'h00));
        send_access(make_access(OP_PORT_READ,  16'h0052, 8'h00));
        send_access(make_access(OP_PORT_READ,  16'h00a1, 8'h00));
        // every key down on player one
        item = make_access(OP_PORT_READ, 16'h00e0, 8'h00);
        item.keypad_one = 16'h0000;
        send_access(item);
        item = make_access(OP_PORT_READ, 16'h00e2, 8'h00);
        item.keypad_two = 16'hffff;
        send_access(item);
        send_access(make_access(OP_PORT_WRITE, 16'h00c0, 8'h00));
        send_access(make_access(OP_PORT_READ,  16'h00e2, 8'h00));
        send_access(make_access(OP_PORT_WRITE, 16'h0080, 8'hff));
        send_access(make_access(OP_PORT_WRITE, 16'h0050, 8'h80));
        send_access(make_access(OP_PORT_WRITE, 16'h0051, 8'h7f));
        send_access(make_access(OP_PORT_WRITE, 16'h00a0, 8'h12));
        send_access(make_access(OP_PORT_WRITE, 16'h00ff, 8'h9f));
        send_access(make_access(OP_PORT_READ,  16'h0000, 8'h00));
        send_access(make_access(OP_PORT_WRITE, 16'h0053, 8'h00));
        send_access(make_access(OP_PORT_WRITE, 16'h0060, 8'h02));
        drain_responses();

        // Random phases, one cartridge setting each; registers change only while
        // the block is empty. Upper data bits of the mode write are junk on purpose.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            bank = (phase_bank[ph] < 0) ? 6'($urandom) : 6'(phase_bank[ph]);
            program_register(CFG_CART_MODE, {4'($urandom), phase_mode[ph]});
            program_register(CFG_LAST_BANK, bank);
            // advance one phase with no idling on either side
            idle_pct  = (ph == 1) ? 0 : 14;
            stall_pct = (ph == 1) ? 0 : 14;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_access(random_access());
            drain_responses();
        end

        // Keep the clock running so a stray response still gets caught
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("console_bus_mapper_tb: PASS");
        else
            $display("console_bus_mapper_tb: FAIL");
        $finish;
    end

endmodule
